[design/swf_pkg.sv]
// Shared types, codes and defaults for the stroke-width map block.
package swf_pkg;

  localparam int IMG_DIM_DEF   = 256;
  localparam int MAX_LEN_DEF   = 128;
  localparam int FRAC_BITS_DEF = 4;

  localparam int COORD_W = 8;
  localparam int WIDTH_W = 12;
  localparam int CFG_W   = 9;

  localparam logic [1:0] FUNC_FILL  = 2'd0;
  localparam logic [1:0] FUNC_LIMIT = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_BAD   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FUNC  = 2'd2;

  localparam logic [1:0] REG_EXCL = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_ROWS = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SQ0, S_SQW, S_RDA, S_RDB,
    S_FA, S_FB, S_CA, S_CB, S_SEL0, S_SRUN, S_STAIL, S_SBIT,
    S_MA, S_MB, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RES_HOLD, RES_ERR, RES_READ, RES_FILL, RES_MED, RES_EMPTY
  } res_t;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic walk_init;
    logic sq_start;
    logic map_rd;
    logic fill_wr;
    logic coll;
    logic clamp_wr;
    logic sel_init;
    logic buf_rd;
    logic sel_bit;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] chk;
    logic [1:0] func;
    logic       walk_last;
    logic       sq_done;
    logic       cnt_zero;
    logic       sel_last;
    logic       bit_last;
  } sts_t;

endpackage

[design/swf_sqrt.sv]
// Bit-serial rounded square root, one result bit per cycle.
module swf_sqrt #(
  parameter int RAD_W = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [RAD_W-1:0]              rad,
  output logic                          done,
  output logic [swf_pkg::WIDTH_W-1:0]   root
);
  localparam int SQW = (RAD_W + 1) / 2;
  localparam int BW  = 2 * SQW;
  localparam int CNW = $clog2(SQW + 1);

  logic [BW-1:0]  rem, res, bm;
  logic [CNW-1:0] cnt;
  logic           run;
  logic [BW:0]    trial;
  logic [BW:0]    rnd;

  assign trial = {1'b0, res} + {1'b0, bm};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= BW'(rad);
        res <= '0;
        bm  <= BW'(1) << (BW - 2);
        cnt <= CNW'(SQW);
        run <= 1'b1;
      end else if (run) begin
        if ({1'b0, rem} >= trial) begin
          rem <= rem - trial[BW-1:0];
          res <= (res >> 1) + bm;
        end else begin
          res <= res >> 1;
        end
        bm  <= bm >> 2;
        cnt <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // round to nearest: bump when remainder exceeds root
  assign rnd  = {1'b0, res} + ((rem > res) ? (BW+1)'(1) : (BW+1)'(0));
  assign root = (rnd > (BW+1)'({swf_pkg::WIDTH_W{1'b1}})) ? {swf_pkg::WIDTH_W{1'b1}}
                                                           : rnd[swf_pkg::WIDTH_W-1:0];
endmodule

[design/swf_dp.sv]
// Datapath: item registers, line walker, width map, median buffer and select.
module swf_dp #(
  parameter int IMG_DIM   = swf_pkg::IMG_DIM_DEF,
  parameter int MAX_LEN   = swf_pkg::MAX_LEN_DEF,
  parameter int FRAC_BITS = swf_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  swf_pkg::cmd_t               cmd,
  output swf_pkg::sts_t               sts,
  input  logic                        excl,
  input  logic [swf_pkg::CFG_W-1:0]   cols,
  input  logic [swf_pkg::CFG_W-1:0]   rows,
  input  logic [1:0]                  func,
  input  logic [7:0]                  x_start,
  input  logic [7:0]                  y_start,
  input  logic [7:0]                  x_end,
  input  logic [7:0]                  y_end,
  output logic [1:0]                  status,
  output logic                        width_valid,
  output logic [11:0]                 width_value,
  output logic [7:0]                  pixels_changed
);
  localparam int DIM   = (IMG_DIM < 256) ? IMG_DIM : 256;
  localparam int CW    = $clog2(DIM);
  localparam int AW    = 2 * CW;
  localparam int LIM_W = ($clog2(IMG_DIM + 1) > 9) ? $clog2(IMG_DIM + 1) : 9;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int RAD_W = 2 * swf_pkg::COORD_W + 1 + 2 * FRAC_BITS;
  localparam int EW    = 12;

  // latched item
  logic [1:0] f_r;
  logic [7:0] xa, ya, xb, yb;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f_r <= func;
      xa  <= x_start;
      ya  <= y_start;
      xb  <= x_end;
      yb  <= y_end;
    end
  end

  logic [7:0]       adx, ady, steps;
  logic [LIM_W-1:0] clim, rlim;
  logic             bad0, bad1;

  assign adx   = (xb > xa) ? xb - xa : xa - xb;
  assign ady   = (yb > ya) ? yb - ya : ya - yb;
  assign steps = (adx > ady) ? adx : ady;
  assign clim  = (LIM_W'(cols) < LIM_W'(IMG_DIM)) ? LIM_W'(cols) : LIM_W'(IMG_DIM);
  assign rlim  = (LIM_W'(rows) < LIM_W'(IMG_DIM)) ? LIM_W'(rows) : LIM_W'(IMG_DIM);
  assign bad0  = (LIM_W'(xa) >= clim) || (LIM_W'(ya) >= rlim);
  assign bad1  = (LIM_W'(xb) >= clim) || (LIM_W'(yb) >= rlim);

  always_comb begin
    if (f_r == swf_pkg::FUNC_BAD)                 sts.chk = swf_pkg::ST_FUNC;
    else if (bad0)                                sts.chk = swf_pkg::ST_RANGE;
    else if (f_r == swf_pkg::FUNC_READ)           sts.chk = swf_pkg::ST_OK;
    else if (bad1)                                sts.chk = swf_pkg::ST_RANGE;
    else if (32'(steps) >= MAX_LEN)               sts.chk = swf_pkg::ST_RANGE;
    else                                          sts.chk = swf_pkg::ST_OK;
  end
  assign sts.func = f_r;

  // Bresenham walker
  logic [7:0]          wx, wy;
  logic signed [EW-1:0] werr, e2, dxs, dys, nerr;
  logic [7:0]          nx, ny;

  assign dxs = $signed({{(EW-8){1'b0}}, adx});
  assign dys = $signed({{(EW-8){1'b0}}, ady});
  assign e2  = werr <<< 1;

  always_comb begin
    nerr = werr;
    nx   = wx;
    ny   = wy;
    if (e2 > -dys) begin
      nerr = nerr - dys;
      nx   = (xa < xb) ? wx + 8'd1 : wx - 8'd1;
    end
    if (e2 < dxs) begin
      nerr = nerr + dxs;
      ny   = (ya < yb) ? wy + 8'd1 : wy - 8'd1;
    end
  end

  logic adv;
  assign adv = cmd.fill_wr | cmd.coll | cmd.clamp_wr;

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      wx   <= xa;
      wy   <= ya;
      werr <= dxs - dys;
    end else if (adv) begin
      wx   <= nx;
      wy   <= ny;
      werr <= nerr;
    end
  end

  logic is_end;
  assign sts.walk_last = (wx == xb) && (wy == yb);
  assign is_end        = ((wx == xa) && (wy == ya)) || sts.walk_last;

  // fill length
  logic [15:0]      asq, bsq;
  logic [RAD_W-1:0] rad;
  logic [11:0]      len;

  always_ff @(posedge clk) begin
    asq <= adx * adx;
    bsq <= ady * ady;
  end
  assign rad = RAD_W'({1'b0, asq} + {1'b0, bsq}) << (2 * FRAC_BITS);

  swf_sqrt #(.RAD_W(RAD_W)) u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.sq_start),
    .rad  (rad),
    .done (sts.sq_done),
    .root (len)
  );

  // width map: valid bit over width
  logic [12:0]   wmap [2**AW];
  logic [12:0]   mrd;
  logic [AW-1:0] clr_cnt, pix_addr, waddr;
  logic [12:0]   wdata;
  logic          mwe;
  logic [11:0]   ans;
  logic          fill_ok, clamp_ok, coll_ok;

  assign pix_addr = {wy[CW-1:0], wx[CW-1:0]};
  assign fill_ok  = (!mrd[12] || (len < mrd[11:0])) && !(excl && is_end);
  assign clamp_ok = mrd[12] && (mrd[11:0] > ans);
  assign coll_ok  = mrd[12] && (mrd[11:0] != 12'd0);

  always_comb begin
    mwe   = 1'b0;
    waddr = pix_addr;
    wdata = {1'b1, len};
    if (cmd.clr_en) begin
      mwe   = 1'b1;
      waddr = clr_cnt;
      wdata = '0;
    end else if (cmd.fill_wr && fill_ok) begin
      mwe = 1'b1;
    end else if (cmd.clamp_wr && clamp_ok) begin
      mwe   = 1'b1;
      wdata = {1'b1, ans};
    end
  end

  always_ff @(posedge clk) begin
    if (mwe) wmap[waddr] <= wdata;
    if (cmd.map_rd) mrd <= wmap[pix_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_en) clr_cnt <= clr_cnt + 1'b1;
  end
  assign sts.clr_last = &clr_cnt;

  // median buffer and radix select
  logic [11:0]      mbuf [MAX_LEN];
  logic [11:0]      bdata;
  logic [CNT_W-1:0] cnt, lt;
  logic [IDX_W-1:0] sidx;
  logic             rd_vld;
  logic [3:0]       bpos;
  logic [11:0]      cand;

  assign cand = ans | (12'd1 << bpos);

  always_ff @(posedge clk) begin
    if (cmd.coll && coll_ok) mbuf[cnt[IDX_W-1:0]] <= mrd[11:0];
    if (cmd.buf_rd) bdata <= mbuf[sidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      cnt    <= '0;
    end else begin
      rd_vld <= cmd.buf_rd;
      if (cmd.load) cnt <= '0;
      else if (cmd.coll && coll_ok) cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel_init) begin
      ans  <= '0;
      bpos <= 4'd11;
      sidx <= '0;
      lt   <= '0;
    end else if (cmd.sel_bit) begin
      if (lt <= (cnt >> 1)) ans <= cand;
      bpos <= bpos - 4'd1;
      sidx <= '0;
      lt   <= '0;
    end else begin
      if (cmd.buf_rd) sidx <= sidx + 1'b1;
      if (rd_vld && (bdata < cand)) lt <= lt + 1'b1;
    end
  end

  assign sts.cnt_zero = (cnt == '0);
  assign sts.sel_last = (CNT_W'(sidx) == cnt - 1'b1);
  assign sts.bit_last = (bpos == 4'd0);

  // result
  logic [7:0] chg;
  always_ff @(posedge clk) begin
    if (rst) begin
      chg <= '0;
    end else if (cmd.load) begin
      chg <= '0;
    end else if ((cmd.fill_wr && fill_ok) || (cmd.clamp_wr && clamp_ok)) begin
      if (chg != 8'hFF) chg <= chg + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.res)
      swf_pkg::RES_ERR: begin
        status      <= sts.chk;
        width_valid <= 1'b0;
        width_value <= '0;
      end
      swf_pkg::RES_READ: begin
        status      <= swf_pkg::ST_OK;
        width_valid <= mrd[12];
        width_value <= mrd[12] ? mrd[11:0] : 12'd0;
      end
      swf_pkg::RES_FILL: begin
        status      <= swf_pkg::ST_OK;
        width_valid <= 1'b1;
        width_value <= len;
      end
      swf_pkg::RES_MED: begin
        status      <= swf_pkg::ST_OK;
        width_valid <= 1'b1;
        width_value <= ans;
      end
      swf_pkg::RES_EMPTY: begin
        status      <= swf_pkg::ST_OK;
        width_valid <= 1'b0;
        width_value <= '0;
      end
      default: ;
    endcase
  end
  assign pixels_changed = chg;
endmodule

[design/swf_ctrl.sv]
// Controller: sequences clear, check, pixel read, length, walks and median select.
module swf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  swf_pkg::sts_t  sts,
  output swf_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);
  swf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= swf_pkg::S_CLEAR;
    else     state <= state_next;
  end

  assign busy = (state != swf_pkg::S_IDLE);
  assign done = (state == swf_pkg::S_DONE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      swf_pkg::S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_next = swf_pkg::S_IDLE;
      end
      swf_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = swf_pkg::S_CHECK;
        end
      end
      swf_pkg::S_CHECK: begin
        cmd.walk_init = 1'b1;
        if (sts.chk != swf_pkg::ST_OK) begin
          cmd.res    = swf_pkg::RES_ERR;
          state_next = swf_pkg::S_DONE;
        end else begin
          case (sts.func)
            swf_pkg::FUNC_READ:  state_next = swf_pkg::S_RDA;
            swf_pkg::FUNC_FILL:  state_next = swf_pkg::S_SQ0;
            swf_pkg::FUNC_LIMIT: state_next = swf_pkg::S_CA;
            default: begin
              cmd.res    = swf_pkg::RES_ERR;
              state_next = swf_pkg::S_DONE;
            end
          endcase
        end
      end
      swf_pkg::S_RDA: begin
        cmd.map_rd = 1'b1;
        state_next = swf_pkg::S_RDB;
      end
      swf_pkg::S_RDB: begin
        cmd.res    = swf_pkg::RES_READ;
        state_next = swf_pkg::S_DONE;
      end
      swf_pkg::S_SQ0: begin
        cmd.sq_start = 1'b1;
        state_next   = swf_pkg::S_SQW;
      end
      swf_pkg::S_SQW: begin
        if (sts.sq_done) state_next = swf_pkg::S_FA;
      end
      swf_pkg::S_FA: begin
        cmd.map_rd = 1'b1;
        state_next = swf_pkg::S_FB;
      end
      swf_pkg::S_FB: begin
        cmd.fill_wr = 1'b1;
        if (sts.walk_last) begin
          cmd.res    = swf_pkg::RES_FILL;
          state_next = swf_pkg::S_DONE;
        end else begin
          state_next = swf_pkg::S_FA;
        end
      end
      swf_pkg::S_CA: begin
        cmd.map_rd = 1'b1;
        state_next = swf_pkg::S_CB;
      end
      swf_pkg::S_CB: begin
        cmd.coll   = 1'b1;
        state_next = sts.walk_last ? swf_pkg::S_SEL0 : swf_pkg::S_CA;
      end
      swf_pkg::S_SEL0: begin
        if (sts.cnt_zero) begin
          cmd.res    = swf_pkg::RES_EMPTY;
          state_next = swf_pkg::S_DONE;
        end else begin
          cmd.sel_init = 1'b1;
          state_next   = swf_pkg::S_SRUN;
        end
      end
      swf_pkg::S_SRUN: begin
        cmd.buf_rd = 1'b1;
        if (sts.sel_last) state_next = swf_pkg::S_STAIL;
      end
      swf_pkg::S_STAIL: begin
        state_next = swf_pkg::S_SBIT;
      end
      swf_pkg::S_SBIT: begin
        cmd.sel_bit = 1'b1;
        if (sts.bit_last) begin
          cmd.walk_init = 1'b1;
          state_next    = swf_pkg::S_MA;
        end else begin
          state_next = swf_pkg::S_SRUN;
        end
      end
      swf_pkg::S_MA: begin
        cmd.map_rd = 1'b1;
        state_next = swf_pkg::S_MB;
      end
      swf_pkg::S_MB: begin
        cmd.clamp_wr = 1'b1;
        if (sts.walk_last) begin
          cmd.res    = swf_pkg::RES_MED;
          state_next = swf_pkg::S_DONE;
        end else begin
          state_next = swf_pkg::S_MA;
        end
      end
      swf_pkg::S_DONE: begin
        state_next = swf_pkg::S_IDLE;
      end
      default: state_next = swf_pkg::S_IDLE;
    endcase
  end
endmodule

[design/stroke_width_map_fill_median.sv]
// Top level: stroke-width map with fill, median limit and pixel read.
//
//   channel   ports                                   handshake
//   command   func x_start y_start x_end y_end        start & !busy
//   result    status width_valid width_value          done, one cycle
//             pixels_changed
//   config    psel penable pwrite paddr pwdata        APB, pready tied high
//             prdata pready
//
// One word in, one word out. An item with n walked pixels runs these steps:
//   read: one map read, then the result; error: the check, then the result;
//   fill: the root unit, then one map read and one write slot per pixel;
//   limit: two map walks plus twelve radix passes over the buffer port.
// After reset a clearing pass writes every map entry, 2^(2*ceil(log2(min(IMG_DIM,
// 256)))) of them (65536 by default); busy stays high and config writes still land.
// done pulses for one cycle; the receiver cannot stall it.
module stroke_width_map_fill_median #(
  parameter int IMG_DIM   = swf_pkg::IMG_DIM_DEF,
  parameter int MAX_LEN   = swf_pkg::MAX_LEN_DEF,
  parameter int FRAC_BITS = swf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [7:0]  x_start,
  input  logic [7:0]  y_start,
  input  logic [7:0]  x_end,
  input  logic [7:0]  y_end,
  output logic        done,
  output logic [1:0]  status,
  output logic        width_valid,
  output logic [11:0] width_value,
  output logic [7:0]  pixels_changed,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  // config registers
  logic                      excl;
  logic [swf_pkg::CFG_W-1:0] cols, rows;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      excl <= 1'b1;
      cols <= 9'd256;
      rows <= 9'd256;
    end else if (wr_en) begin
      case (paddr[3:2])
        swf_pkg::REG_EXCL: excl <= pwdata[0];
        swf_pkg::REG_COLS: cols <= pwdata[swf_pkg::CFG_W-1:0];
        swf_pkg::REG_ROWS: rows <= pwdata[swf_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      swf_pkg::REG_EXCL: prdata = {31'd0, excl};
      swf_pkg::REG_COLS: prdata = {23'd0, cols};
      swf_pkg::REG_ROWS: prdata = {23'd0, rows};
      default:           prdata = '0;
    endcase
  end

  swf_pkg::cmd_t cmd;
  swf_pkg::sts_t sts;

  swf_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  swf_dp #(
    .IMG_DIM  (IMG_DIM),
    .MAX_LEN  (MAX_LEN),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .excl          (excl),
    .cols          (cols),
    .rows          (rows),
    .func          (func),
    .x_start       (x_start),
    .y_start       (y_start),
    .x_end         (x_end),
    .y_end         (y_end),
    .status        (status),
    .width_valid   (width_valid),
    .width_value   (width_value),
    .pixels_changed(pixels_changed)
  );

  // a result word only leaves while an item is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // an accepted word starts work at once
  a_accept: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // one result per word
  a_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for two cycles");

  // rejected words leave no trace in the result
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != swf_pkg::ST_OK) |->
      (!width_valid && width_value == 12'd0 && pixels_changed == 8'd0))
    else $error("error result carries data");
endmodule
